[sv/uts_pkg.sv]
// shared types and constants of the utf-8 text sanitizer
package uts_pkg;

  localparam int unsigned MSG_COLUMNS = 24;
  localparam int unsigned MSG_ROWS    = 2;
  localparam logic [7:0]  MAX_CHARS_RESET = 8'(MSG_COLUMNS * MSG_ROWS);

  // characters held back so that a cut message can end in "..."
  localparam int unsigned HOLD_DEPTH = 3;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [6:0] CHAR_QMARK = 7'h3F;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;

  localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_FLUSH,
    TAIL_TRUNC
  } tail_e;

  // one command: n characters to produce, then an optional message end
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][6:0] chars;
    tail_e           tail;
  } cmd_t;

endpackage

[sv/utf8_text_sanitizer.sv]
// top level of the utf-8 text sanitizer
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_item_i  (char_byte, end_of_text)
//   out     | output    | out_valid_o / out_stall_i  | out_item_o (out_char, last)
//   cfg     | input     | cfg_we_i                   | cfg_wdata_i (max_chars)
//
// an item is taken every cycle while the four-entry command queue has room
// the back produces one character per cycle unless a stalled output holds it; an item
// that emits held chars (message end, truncation) keeps it busy while they go out, so
// bursts are absorbed by the queue and the input stalls only when it fills
// reset clears parser state, counters, queue and output valid; max_chars
// returns to 48; no clearing pass
// a stalled output holds its register, and the back keeps working on items
// that only fill the hold-back line
module utf8_text_sanitizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uts_pkg::out_item_t out_item_o
);

  logic [7:0]    max_chars_q;
  logic          cmdq_full;
  logic          cmd_push;
  uts_pkg::cmd_t cmd;
  logic          head_valid;
  uts_pkg::cmd_t head_cmd;
  logic          head_pop;

  // single configuration register: output cap per message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= uts_pkg::MAX_CHARS_RESET;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  // front: parse utf-8, count characters against the cap, build commands
  uts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_chars_i (max_chars_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmdq_full_i (cmdq_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd)
  );

  // decouples parsing from character output
  uts_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_push),
    .push_cmd_i   (cmd),
    .full_o       (cmdq_full),
    .pop_i        (head_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // back: hold three characters, emit, and replace them with dots on truncation when all three are held
  uts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (head_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

[sv/uts_front.sv]
// front: utf-8 parsing, cap accounting and command generation
module uts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       max_chars_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uts_pkg::in_item_t in_item_i,
  input  logic             cmdq_full_i,
  output logic             cmd_push_o,
  output uts_pkg::cmd_t    cmd_o
);

  logic       lead_q, lead_d;
  logic [1:0] need_q, need_d;
  logic [1:0] seen_q, seen_d;
  logic [7:0] emitted_q, emitted_d;
  logic       discard_q, discard_d;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       is_cont;
  logic [6:0] main_char;
  logic [1:0] extra;
  logic [1:0] seen_inc;
  logic       complete;
  logic [1:0] nq;
  logic       has_main;
  logic [1:0] total;
  logic [7:0] avail;
  logic       trunc;
  logic [1:0] n_exec;

  assign in_stall_o = cmdq_full_i;
  assign accept     = in_valid_i && !cmdq_full_i;
  assign b          = in_item_i.char_byte;
  assign eot        = in_item_i.end_of_text;
  assign is_cont    = (b[7:6] == 2'b10);
  assign seen_inc   = seen_q + 2'd1;
  assign complete   = (seen_inc >= need_q);

  // character for a byte handled as a new byte, and the number of continuation bytes it announces
  always_comb begin
    if (b >= uts_pkg::BYTE_PRINT_LO && b <= uts_pkg::BYTE_PRINT_HI) begin
      main_char = b[6:0];
    end else if (b == uts_pkg::BYTE_LF || b == uts_pkg::BYTE_CR ||
                 b == uts_pkg::BYTE_TAB) begin
      main_char = uts_pkg::CHAR_SPACE;
    end else begin
      main_char = uts_pkg::CHAR_QMARK;
    end
    priority if (b[7:5] == 3'b110) begin
      extra = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      extra = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      extra = 2'd3;
    end else begin
      extra = 2'd0;
    end
  end

  // list of produced characters: nq question marks, then the main one if has_main is set
  always_comb begin
    if (lead_q && is_cont) begin
      nq       = (eot && !complete) ? seen_inc : 2'd0;
      has_main = 1'b0;
    end else if (lead_q) begin
      nq       = seen_q;
      has_main = 1'b1;
    end else begin
      nq       = 2'd0;
      has_main = 1'b1;
    end
    total = nq + {1'b0, has_main};
    avail = (emitted_q >= max_chars_i) ? 8'd0 : (max_chars_i - emitted_q);
    trunc = ({6'd0, total} > avail);
    n_exec = trunc ? avail[1:0] : total;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmd_o.chars[i] = (2'(i) < nq) ? uts_pkg::CHAR_QMARK : main_char;
    end
    cmd_o.n = n_exec;
    if (trunc) begin
      cmd_o.tail = uts_pkg::TAIL_TRUNC;
    end else if (eot) begin
      cmd_o.tail = uts_pkg::TAIL_FLUSH;
    end else begin
      cmd_o.tail = uts_pkg::TAIL_NONE;
    end
    cmd_push_o = accept && !discard_q &&
                 ((n_exec != 2'd0) || (cmd_o.tail != uts_pkg::TAIL_NONE));
  end

  always_comb begin
    lead_d    = lead_q;
    need_d    = need_q;
    seen_d    = seen_q;
    emitted_d = emitted_q;
    discard_d = discard_q;
    if (accept) begin
      if (discard_q) begin
        discard_d = !eot;
      end else if (trunc || eot) begin
        // message over: truncated or ended normally
        discard_d = trunc && !eot;
        lead_d    = 1'b0;
        need_d    = 2'd0;
        seen_d    = 2'd0;
        emitted_d = 8'd0;
      end else begin
        emitted_d = emitted_q + {6'd0, total};
        if (lead_q && is_cont) begin
          if (complete) begin
            lead_d = 1'b0;
            need_d = 2'd0;
            seen_d = 2'd0;
          end else begin
            seen_d = seen_inc;
          end
        end else begin
          lead_d = (extra != 2'd0);
          need_d = extra;
          seen_d = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= 1'b0;
      need_q    <= 2'd0;
      seen_q    <= 2'd0;
      emitted_q <= 8'd0;
      discard_q <= 1'b0;
    end else begin
      lead_q    <= lead_d;
      need_q    <= need_d;
      seen_q    <= seen_d;
      emitted_q <= emitted_d;
      discard_q <= discard_d;
    end
  end

endmodule

[sv/uts_cmdq.sv]
// small command queue between front and back
module uts_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uts_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output uts_pkg::cmd_t head_cmd_o
);

  uts_pkg::cmd_t                 entries_q [uts_pkg::CMDQ_DEPTH];
  logic [uts_pkg::CMDQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [uts_pkg::CMDQ_AW:0]     count_q;
  logic                          do_pop;

  assign full_o       = (count_q == (uts_pkg::CMDQ_AW+1)'(uts_pkg::CMDQ_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entries_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/uts_back.sv]
// back: hold-back line of three characters and output register
module uts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  uts_pkg::cmd_t     head_cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uts_pkg::out_item_t out_item_o
);

  logic [6:0] held_q [uts_pkg::HOLD_DEPTH];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] tidx_q, tidx_d;
  logic       out_valid_q, out_valid_d;
  uts_pkg::out_item_t out_q;

  logic       out_free;
  logic       emit;
  logic [6:0] emit_char;
  logic       emit_last;
  logic       shift;
  logic       append;
  logic       advance;
  logic       dots;
  logic [1:0] last_pos;
  logic [6:0] prod_char;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign prod_char   = head_cmd_i.chars[idx_q];
  assign dots        = (head_cmd_i.tail == uts_pkg::TAIL_TRUNC) && (held_cnt_q == 2'd3);
  assign last_pos    = dots ? 2'd2 : (held_cnt_q - 2'd1);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    pop_o      = 1'b0;
    emit       = 1'b0;
    emit_char  = held_q[0];
    emit_last  = 1'b0;
    shift      = 1'b0;
    append     = 1'b0;
    advance    = 1'b0;
    idx_d      = idx_q;
    tidx_d     = tidx_q;
    held_cnt_d = held_cnt_q;
    if (head_valid_i) begin
      if (idx_q != head_cmd_i.n) begin
        // produce one character
        if (held_cnt_q == 2'd3) begin
          if (out_free) begin
            emit    = 1'b1;
            shift   = 1'b1;
            advance = 1'b1;
          end
        end else begin
          append     = 1'b1;
          advance    = 1'b1;
          held_cnt_d = held_cnt_q + 2'd1;
        end
        if (advance) begin
          idx_d = idx_q + 2'd1;
          if ((idx_q + 2'd1 == head_cmd_i.n) &&
              (head_cmd_i.tail == uts_pkg::TAIL_NONE)) begin
            pop_o = 1'b1;
            idx_d = 2'd0;
          end
        end
      end else begin
        unique case (head_cmd_i.tail)
          uts_pkg::TAIL_FLUSH, uts_pkg::TAIL_TRUNC: begin
            if (!dots && held_cnt_q == 2'd0) begin
              // nothing held, message ends with no output
              pop_o = 1'b1;
              idx_d = 2'd0;
            end else if (out_free) begin
              emit      = 1'b1;
              emit_char = dots ? uts_pkg::CHAR_DOT : held_q[tidx_q];
              emit_last = (tidx_q == last_pos);
              if (emit_last) begin
                pop_o      = 1'b1;
                idx_d      = 2'd0;
                tidx_d     = 2'd0;
                held_cnt_d = 2'd0;
              end else begin
                tidx_d = tidx_q + 2'd1;
              end
            end
          end
          default: begin
            pop_o = 1'b1;
            idx_d = 2'd0;
          end
        endcase
      end
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      held_q[0] <= held_q[1];
      held_q[1] <= held_q[2];
      held_q[2] <= prod_char;
    end else if (append) begin
      held_q[held_cnt_q] <= prod_char;
    end
    if (emit) begin
      out_q.out_char <= emit_char;
      out_q.last     <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q  <= 2'd0;
      idx_q       <= 2'd0;
      tidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      held_cnt_q  <= held_cnt_d;
      idx_q       <= idx_d;
      tidx_q      <= tidx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
